FILE: hw/rtl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds character codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package sitda_pkg;

    localparam int CHAR_W = 6;
    localparam int BCD_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // double dabble: digits at or above this get +3 before the shift
    localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [BCD_W-1:0] BCD_ADJ_ADD = 4'd3;

    typedef struct packed {
        logic load;
        logic shift;
        logic scan;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic negative;
        logic idx_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sitda_num_if.sv
// Input channel interface: one signed integer per transaction.
// Depends on nothing.
`default_nettype none

interface sitda_num_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sitda_text_if.sv
// Output channel interface: one ASCII character per transaction.
// Depends on sitda_pkg.
`default_nettype none

interface sitda_text_if;
    logic                          valid;
    logic                          ready;
    logic [sitda_pkg::CHAR_W-1:0]  character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter. Each transaction on num carries one
// two's complement integer of DATA_WIDTH bits; text returns its decimal digits,
// most significant first, one character per transaction, preceded by '-' for a
// negative value, with no leading zeros and last set on the final character.
// The most negative value converts exactly. One number is processed at a time:
// the input is taken, shift-and-add-3 steps, one per input bit, build the BCD
// digits, a scan finds the leading digit, then characters leave one per cycle
// while text is ready. The next number is accepted as soon as its predecessor's
// final character is in the output register.
// Depends on sitda_pkg, sitda_num_if, sitda_text_if, sitda_ctrl, sitda_dp.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    sitda_num_if.sink    num,
    sitda_text_if.source text
);
    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t status;

    sitda_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num.valid),
        .in_ready (num.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sitda_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (num.value),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (text.valid),
        .out_ready     (text.ready),
        .out_character (text.character),
        .out_last      (text.last)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/sitda_ctrl.sv
// Controller FSM: sequences load, double-dabble shifts, digit scan and emission.
// Depends on sitda_pkg.
`default_nettype none

module sitda_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sitda_pkg::status_t status,
    output sitda_pkg::cmd_t        cmd
);
    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_SCAN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = status.negative ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.idx_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sitda_dp.sv
// Datapath: magnitude and BCD shift registers (double dabble), leading-digit
// scan, and the output character register. Depends on sitda_pkg.
`default_nettype none

module sitda_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [DATA_WIDTH-1:0]  value,
    input  wire sitda_pkg::cmd_t               cmd,
    output sitda_pkg::status_t                 status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sitda_pkg::CHAR_W-1:0]       out_character,
    output logic                               out_last
);
    // enough digits for 2^(DATA_WIDTH-1)
    localparam int NDIG  = (DATA_WIDTH * 3) / 10 + 1;
    localparam int BCD_N = NDIG * sitda_pkg::BCD_W;
    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [DATA_WIDTH-1:0]          mag_reg, mag_next;
    logic [BCD_N-1:0]               bcd_reg, bcd_next;
    logic                           neg_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic                           out_valid_reg;
    logic [sitda_pkg::CHAR_W-1:0]   char_reg;
    logic                           last_reg;

    logic [BCD_N-1:0]               bcd_adj;
    logic [IDX_W-1:0]               idx_scan;
    logic [sitda_pkg::BCD_W-1:0]    digit;
    logic                           out_free;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] >= sitda_pkg::BCD_ADJ_MIN)
                bcd_adj[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] =
                    bcd_reg[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] + sitda_pkg::BCD_ADJ_ADD;
            else
                bcd_adj[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] =
                    bcd_reg[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W];
        end
    end

    always_comb
    begin
        idx_scan = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] != '0)
                idx_scan = IDX_W'(i);
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            mag_next = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
            bcd_next = '0;
        end
        else if (cmd.shift)
        begin
            mag_next = {mag_reg[DATA_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_N-2:0], mag_reg[DATA_WIDTH-1]};
        end
    end

    assign digit    = bcd_reg[idx_reg*sitda_pkg::BCD_W +: sitda_pkg::BCD_W];
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        if (cmd.load)
            neg_reg <= value[DATA_WIDTH-1];
        if (cmd.scan)
            idx_reg <= idx_scan;
        else if (cmd.emit_digit)
            idx_reg <= idx_reg - 1'b1;
        if (cmd.emit_sign)
        begin
            char_reg <= sitda_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digit);
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_sign || cmd.emit_digit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.negative = neg_reg;
    assign status.idx_zero = (idx_reg == '0);
    assign status.out_free = out_free;

    assign out_valid     = out_valid_reg;
    assign out_character = char_reg;
    assign out_last      = last_reg;

endmodule

`default_nettype wire
